// ===== src/lrupr_pkg.sv =====
package lrupr_pkg;

	// Widest page number and frame index that the core supports; the chain
	// between cells carries fields of these widths, zero-extended.
	localparam int MAX_PAGE_BITS = 32;
	localparam int MAX_IDX_BITS  = 4;

	// Search result handed from one frame cell to the next.
	typedef struct packed {
		logic                     hit_found;
		logic [MAX_IDX_BITS-1:0]  hit_idx;
		logic [MAX_IDX_BITS-1:0]  hit_rank;
		logic [MAX_IDX_BITS-1:0]  vic_idx;
		logic                     vic_valid;
		logic [MAX_PAGE_BITS-1:0] vic_page;
	} chain_t;

	// Update command broadcast to every cell when a reference is taken.
	typedef struct packed {
		logic                    en;
		logic [MAX_IDX_BITS-1:0] sel_idx;
		logic [MAX_IDX_BITS-1:0] sel_rank;
	} upd_t;

endpackage

// ===== src/lrupr_cell.sv =====
module lrupr_cell #(
	parameter int NUM_FRAMES = 4,
	parameter int PAGE_BITS  = 8,
	parameter int IDX_BITS   = 2,
	parameter int CELL_IDX   = 0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [PAGE_BITS-1:0] ref_page,
	input  lrupr_pkg::chain_t    chain_in,
	input  lrupr_pkg::upd_t      upd,
	output lrupr_pkg::chain_t    chain_out
);

	localparam int MPB = lrupr_pkg::MAX_PAGE_BITS;
	localparam int MIB = lrupr_pkg::MAX_IDX_BITS;
	localparam logic [IDX_BITS-1:0] RANK_OLDEST = IDX_BITS'(NUM_FRAMES - 1);
	localparam logic [IDX_BITS-1:0] RANK_INIT   = IDX_BITS'(NUM_FRAMES - 1 - CELL_IDX);
	localparam logic [MIB-1:0]      MY_IDX      = MIB'(CELL_IDX);

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic [IDX_BITS-1:0]  rank_q;
	logic                 match;
	logic                 oldest;
	logic                 chosen;

	assign match  = valid_q && (page_q == ref_page);
	assign oldest = (rank_q == RANK_OLDEST);
	assign chosen = (upd.sel_idx == MY_IDX);

	// The first matching cell claims the hit; the oldest cell offers itself as victim.
	always_comb begin
		chain_out = chain_in;
		if (!chain_in.hit_found && match) begin
			chain_out.hit_found = 1'b1;
			chain_out.hit_idx   = MY_IDX;
			chain_out.hit_rank  = MIB'(rank_q);
		end
		if (oldest) begin
			chain_out.vic_idx   = MY_IDX;
			chain_out.vic_valid = valid_q;
			chain_out.vic_page  = valid_q ? MPB'(page_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rank_q  <= RANK_INIT;
		end else if (upd.en) begin
			if (chosen) begin
				valid_q <= 1'b1;
				rank_q  <= '0;
			end else if (MIB'(rank_q) < upd.sel_rank) begin
				rank_q <= rank_q + IDX_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd.en && chosen) begin
			page_q <= ref_page;
		end
	end

endmodule

// ===== src/lru_page_replacement_core.sv =====
// Fully associative LRU page-frame store built as a row of frame cells.
//
// Command channel: a reference transfer happens at a rising clock edge where
// start is high and busy is low; page_number names the page. Result channel:
// in the cycle after each transfer, done is high for a single cycle and
// hit, frame_index, evicted_valid, evicted_page and miss_total hold the
// outcome of that reference. The receiver cannot stall the result; it must
// take it in the cycle that done marks.
//
// For each reference the search runs combinationally down the row of cells
// (first matching frame, and the frame holding the oldest rank), and the
// selected frame and every rank are updated at the edge that takes it.
// A new reference can therefore be taken every cycle.
//
// Reset clears all frames to empty, ranks them so frame 0 is the oldest
// (frames fill in index order) and clears the miss counter. busy is high
// during reset and until the next rising clock edge, then stays low.
module lru_page_replacement_core #(
	parameter int NUM_FRAMES = 4,
	parameter int PAGE_BITS  = 8,
	parameter int COUNT_BITS = 16,
	localparam int IDX_BITS  = $clog2(NUM_FRAMES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [PAGE_BITS-1:0]  page_number,
	output logic                  done,
	output logic                  hit,
	output logic [IDX_BITS-1:0]   frame_index,
	output logic                  evicted_valid,
	output logic [PAGE_BITS-1:0]  evicted_page,
	output logic [COUNT_BITS-1:0] miss_total
);

	localparam int MIB = lrupr_pkg::MAX_IDX_BITS;
	localparam logic [MIB-1:0] RANK_OLDEST = MIB'(NUM_FRAMES - 1);

	lrupr_pkg::chain_t chain [NUM_FRAMES+1];
	lrupr_pkg::upd_t   upd;

	logic                  busy_q;
	logic                  accept;
	logic                  found;
	logic [MIB-1:0]        sel_idx;
	logic [COUNT_BITS-1:0] miss_q;
	logic [COUNT_BITS-1:0] miss_next;

	logic                  done_q;
	logic                  hit_q;
	logic [IDX_BITS-1:0]   frame_q;
	logic                  ev_valid_q;
	logic [PAGE_BITS-1:0]  ev_page_q;

	assign accept = start && !busy_q;

	// The row starts with nothing found; the victim fields are always filled
	// by exactly one cell, since the ranks are a permutation.
	assign chain[0] = '0;

	for (genvar i = 0; i < NUM_FRAMES; i++) begin : g_cell
		lrupr_cell #(
			.NUM_FRAMES(NUM_FRAMES),
			.PAGE_BITS (PAGE_BITS),
			.IDX_BITS  (IDX_BITS),
			.CELL_IDX  (i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ref_page (page_number),
			.chain_in (chain[i]),
			.upd      (upd),
			.chain_out(chain[i+1])
		);
	end

	// A hit keeps its frame and promotes it; a miss takes the oldest frame.
	assign found   = chain[NUM_FRAMES].hit_found;
	assign sel_idx = found ? chain[NUM_FRAMES].hit_idx : chain[NUM_FRAMES].vic_idx;

	always_comb begin
		upd.en       = accept;
		upd.sel_idx  = sel_idx;
		upd.sel_rank = found ? chain[NUM_FRAMES].hit_rank : RANK_OLDEST;
	end

	// The miss counter sticks at its maximum value.
	assign miss_next = (!found && (miss_q != '1)) ? miss_q + COUNT_BITS'(1) : miss_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			miss_q <= '0;
		end else begin
			busy_q <= 1'b0;
			done_q <= accept;
			if (accept) begin
				miss_q <= miss_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q      <= found;
			frame_q    <= sel_idx[IDX_BITS-1:0];
			ev_valid_q <= !found && chain[NUM_FRAMES].vic_valid;
			ev_page_q  <= found ? '0 : chain[NUM_FRAMES].vic_page[PAGE_BITS-1:0];
		end
	end

	assign busy          = busy_q;
	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_index   = frame_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign miss_total    = miss_q;

endmodule

// ===== src/lrupr_checker.sv =====
module lrupr_checker #(
	parameter int NUM_FRAMES = 4,
	parameter int PAGE_BITS  = 8,
	parameter int COUNT_BITS = 16,
	localparam int IDX_BITS  = $clog2(NUM_FRAMES)
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  start,
	input logic                  busy,
	input logic                  done,
	input logic                  hit,
	input logic [IDX_BITS-1:0]   frame_index,
	input logic                  evicted_valid,
	input logic [PAGE_BITS-1:0]  evicted_page,
	input logic [COUNT_BITS-1:0] miss_total
);

	localparam logic [IDX_BITS-1:0] FRAME_LAST = IDX_BITS'(NUM_FRAMES - 1);

	// Every accepted reference yields its result in the next cycle.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("result did not follow an accepted reference");

	// No result appears without a reference taken in the cycle before.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy))
		else $error("result without a reference");

	// A result names an existing frame, and a hit never displaces a page.
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((frame_index <= FRAME_LAST) &&
			(!hit || (!evicted_valid && evicted_page == '0))))
		else $error("bad frame index or a hit reported an eviction");

	// A miss always leaves a nonzero miss count.
	a_miss_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (miss_total != '0))
		else $error("miss not counted");

	// The miss count does not move between a result and a hit result.
	a_hit_count_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(done && hit && $past(done)) |-> $stable(miss_total))
		else $error("miss count changed on a hit");

endmodule

bind lru_page_replacement_core lrupr_checker #(
	.NUM_FRAMES(NUM_FRAMES),
	.PAGE_BITS (PAGE_BITS),
	.COUNT_BITS(COUNT_BITS)
) u_lrupr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.hit          (hit),
	.frame_index  (frame_index),
	.evicted_valid(evicted_valid),
	.evicted_page (evicted_page),
	.miss_total   (miss_total)
);

// ===== dv/lru_page_replacement_core_tb.sv =====
`timescale 1ns / 1ps

module lru_page_replacement_core_tb;

	// Configuration of the core under test; the testbench runs the defaults.
	localparam int NF        = 4;
	localparam int PB        = 8;
	localparam int CB        = 16;
	localparam int IB        = $clog2(NF);
	localparam int COUNT_MAX = (1 << CB) - 1;

	// Generous cycle budget. A correct run has about 850 transfers, with idle
	// cycles only in its paced parts.
	localparam int CYCLE_LIMIT = 20000;

	// One lookup outcome, in the same order as the result ports.
	typedef struct packed {
		logic          hit;
		logic [IB-1:0] frame;
		logic          ev_valid;
		logic [PB-1:0] ev_page;
		logic [CB-1:0] misses;
	} lookup_t;

	// Tracks the frame contents and recency ranks alongside the core, and
	// keeps the outcomes of accepted references that are still in flight.
	class frame_tracker;
		logic [PB-1:0] page_q[NF];
		bit            valid_q[NF];
		bit [IB-1:0]   rank_q[NF];
		bit [CB-1:0]   misses;
		lookup_t       expected_lookups[$];
		int            error_count;

		function new();
			int i;
			for (i = 0; i < NF; i++) begin
				page_q[i]  = '0;
				valid_q[i] = 1'b0;
				rank_q[i]  = IB'(NF - 1 - i);
			end
			misses      = '0;
			error_count = 0;
		endfunction

		function int pending();
			return expected_lookups.size();
		endfunction

		task report_mismatch(string what, longint unsigned got, longint unsigned want);
			error_count++;
			$display("[%0t] %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		endtask

		// Applies one accepted reference and queues the outcome it must give.
		function void note_reference(logic [PB-1:0] pg);
			lookup_t     r;
			int          sel;
			int          i;
			bit [IB-1:0] old_rank;
			r   = '0;
			sel = -1;
			// An empty frame never matches, even if its stale page is equal.
			for (i = 0; i < NF; i++)
				if (sel < 0 && valid_q[i] && page_q[i] == pg)
					sel = i;
			if (sel >= 0) begin
				r.hit = 1'b1;
			end else begin
				sel = 0;
				for (i = 1; i < NF; i++)
					if (rank_q[i] > rank_q[sel])
						sel = i;
				if (valid_q[sel]) begin
					r.ev_valid = 1'b1;
					r.ev_page  = page_q[sel];
				end
				page_q[sel]  = pg;
				valid_q[sel] = 1'b1;
				if (misses != COUNT_MAX[CB-1:0])
					misses++;
			end
			// Frames that were newer than the chosen one age by one step.
			old_rank = rank_q[sel];
			for (i = 0; i < NF; i++)
				if (i != sel && rank_q[i] < old_rank)
					rank_q[i]++;
			rank_q[sel] = '0;
			r.frame  = IB'(sel);
			r.misses = misses;
			expected_lookups.push_back(r);
		endfunction

		task check_lookup(lookup_t got);
			lookup_t want;
			if (expected_lookups.size() == 0) begin
				report_mismatch("result with no reference outstanding", got, 0);
			end else begin
				want = expected_lookups.pop_front();
				if (got.hit !== want.hit)
					report_mismatch("hit", got.hit, want.hit);
				if (got.frame !== want.frame)
					report_mismatch("frame_index", got.frame, want.frame);
				if (got.ev_valid !== want.ev_valid)
					report_mismatch("evicted_valid", got.ev_valid, want.ev_valid);
				if (got.ev_page !== want.ev_page)
					report_mismatch("evicted_page", got.ev_page, want.ev_page);
				if (got.misses !== want.misses)
					report_mismatch("miss_total", got.misses, want.misses);
			end
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	logic [PB-1:0] page_number;
	logic          done;
	logic          hit;
	logic [IB-1:0] frame_index;
	logic          evicted_valid;
	logic [PB-1:0] evicted_page;
	logic [CB-1:0] miss_total;

	frame_tracker tracker;
	int           cycle_count;

	lru_page_replacement_core #(
		.NUM_FRAMES(NF),
		.PAGE_BITS (PB),
		.COUNT_BITS(CB)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.page_number  (page_number),
		.done         (done),
		.hit          (hit),
		.frame_index  (frame_index),
		.evicted_valid(evicted_valid),
		.evicted_page (evicted_page),
		.miss_total   (miss_total)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Monitor. Everything is sampled at the rising edge, where the values
	// driven at the previous falling edge are stable. A result is checked
	// before the transfer of the same edge is noted, because that result
	// belongs to a reference accepted at the previous edge. The cycle counter
	// here also acts as the watchdog for the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("lru_page_replacement_core_tb: errors");
			$finish;
		end else if (arst_n) begin
			if (done)
				tracker.check_lookup('{hit, frame_index, evicted_valid, evicted_page,
					miss_total});
			if (start && !busy)
				tracker.note_reference(page_number);
		end
	end

	// Presents one reference and holds it until the core takes the transfer.
	// When idling is allowed, start is dropped for a random number of cycles
	// first (about a third of the cycles overall), with junk on the page bus.
	// The task is entered and left at a falling edge, so start is assigned at
	// most once per time step and stays high between back-to-back transfers.
	task automatic send_reference(input logic [PB-1:0] pg, input bit may_idle);
		while (may_idle && $urandom_range(99) < 32) begin
			start       <= 1'b0;
			page_number <= PB'($urandom);
			@(negedge clk);
		end
		start       <= 1'b1;
		page_number <= pg;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	// Holds the command side quiet until every outstanding result is back.
	task automatic drain_results();
		start <= 1'b0;
		@(negedge clk);
		while (tracker.pending() != 0)
			@(negedge clk);
	endtask

	// Random references. Most come from a small working set that is swapped
	// out every few dozen references, so the run sees long runs of hits,
	// evictions under pressure and every rank order; the rest are drawn from
	// the full page range and mostly miss.
	task automatic run_random(input int count, input bit may_idle);
		logic [PB-1:0] pool[6];
		int            pool_size;
		int            k;
		int            j;
		pool_size = 0;
		for (k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				pool_size = $urandom_range(6, 3);
				for (j = 0; j < 6; j++)
					pool[j] = PB'($urandom);
			end
			if ($urandom_range(99) < 65)
				send_reference(pool[$urandom_range(pool_size - 1)], may_idle);
			else
				send_reference(PB'($urandom_range(255)), may_idle);
		end
	endtask

	initial begin
		tracker     = new();
		cycle_count = 0;
		arst_n      = 1'b0;
		start       = 1'b0;
		page_number = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. After reset every frame is empty and its page is not
		// reset, so a reference to page zero must still miss into frame 0.
		// The next references fill the frames in index order, then hits on
		// the oldest, the newest and a middle frame reshuffle the ranks before
		// misses evict whatever is now least recent.
		send_reference(8'h00, 1'b0);
		send_reference(8'h00, 1'b0);
		send_reference(8'hFF, 1'b0);
		send_reference(8'h55, 1'b1);
		send_reference(8'hAA, 1'b0);
		send_reference(8'hAA, 1'b0);
		send_reference(8'h00, 1'b1);
		send_reference(8'h55, 1'b0);
		send_reference(8'h0F, 1'b0);
		send_reference(8'hF0, 1'b0);
		send_reference(8'h55, 1'b1);
		send_reference(8'h0F, 1'b0);
		send_reference(8'h01, 1'b0);
		send_reference(8'h80, 1'b0);
		send_reference(8'hFF, 1'b1);
		send_reference(8'h01, 1'b0);
		send_reference(8'hFE, 1'b0);
		send_reference(8'h7F, 1'b0);
		send_reference(8'h7F, 1'b0);
		send_reference(8'h00, 1'b0);

		// Random part: paced, then a long stretch at full rate, then paced
		// again after the command side has let everything drain once.
		run_random(300, 1'b1);
		run_random(200, 1'b0);
		drain_results();
		run_random(290, 1'b1);
		drain_results();

		// A short paced tail after a second drain.
		run_random(40, 1'b1);

		// Wind down: wait for the last results, then let the clock run on
		// in case the core emits anything unexpected.
		drain_results();
		repeat (4) @(posedge clk);
		if (tracker.error_count == 0)
			$display("lru_page_replacement_core_tb: clean");
		else
			$display("lru_page_replacement_core_tb: errors");
		$finish;
	end

endmodule

// ===== lru_page_replacement_core.f =====
src/lrupr_pkg.sv
src/lrupr_cell.sv
src/lru_page_replacement_core.sv
src/lrupr_checker.sv
dv/lru_page_replacement_core_tb.sv
